FILE: hw/rtl/rsdz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radial stick dead zone package
// Shared widths, register indexes and reset values of the dead zone unit.
// ----------------------------------------------------------------------------
package rsdz_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int OUT_FRAC_BITS = 14;
	localparam int LEN_FRAC      = 8;

	localparam int MAG_W  = SAMPLE_BITS;
	localparam int SUM_W  = 2 * SAMPLE_BITS;
	localparam int LEN_W  = SAMPLE_BITS + LEN_FRAC;
	localparam int RAD_W  = 16;
	localparam int F_W    = OUT_FRAC_BITS + 1;
	localparam int PROD_W = MAG_W + F_W + LEN_FRAC;
	localparam int OUT_W  = 16;

	localparam logic [F_W-1:0]   F_ONE   = F_W'(1) << OUT_FRAC_BITS;
	localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1) << OUT_FRAC_BITS;

	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEAD_RADIUS = 1'b0,
		REG_FULL_RADIUS = 1'b1
	} cfg_reg_t;

	localparam logic [RAD_W-1:0] DEAD_RESET = 16'd8000;
	localparam logic [RAD_W-1:0] FULL_RESET = 16'd30000;

endpackage
`default_nettype wire

FILE: hw/rtl/rsdz_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rsdz_sqrt #(
	parameter int RW    = 24,
	parameter int TAG_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2*RW-1:0]   radicand,
	input  wire logic [TAG_W-1:0]  in_tag,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [RW-1:0]          root,
	output logic [TAG_W-1:0]       out_tag
);

	logic              v_s    [1:RW];
	logic [2*RW-1:0]   rad_s  [1:RW];
	logic [RW:0]       rem_s  [1:RW];
	logic [RW-1:0]     root_s [1:RW];
	logic [TAG_W-1:0]  tag_s  [1:RW];
	logic              rdy    [1:RW+1];

	assign rdy[RW+1] = out_ready;

	for (genvar k = 1; k <= RW; k++) begin : g_stage
		logic              v_in;
		logic [2*RW-1:0]   rad_in;
		logic [RW:0]       rem_in;
		logic [RW-1:0]     root_in;
		logic [TAG_W-1:0]  tag_in;
		logic [RW+2:0]     rem2;
		logic [RW+2:0]     trial;
		logic              ge;

		if (k == 1) begin : g_first
			assign v_in    = in_valid;
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign tag_in  = in_tag;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign tag_in  = tag_s[k-1];
		end

		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_comb begin
			rem2  = {rem_in, rad_in[2*RW-1 -: 2]};
			trial = {1'b0, root_in, 2'b01};
			ge    = rem2 >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_in) begin
				rad_s[k]  <= rad_in << 2;
				rem_s[k]  <= ge ? (RW+1)'(rem2 - trial) : rem2[RW:0];
				root_s[k] <= {root_in[RW-2:0], ge};
				tag_s[k]  <= tag_in;
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = v_s[RW];
	assign root      = root_s[RW];
	assign out_tag   = tag_s[RW];

endmodule
`default_nettype wire

FILE: hw/rtl/rsdz_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, several lanes sharing one divisor.
// ----------------------------------------------------------------------------
module rsdz_div #(
	parameter int LANES = 1,
	parameter int Q_W   = 14,
	parameter int D_W   = 24,
	parameter int TAG_W = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [LANES-1:0][D_W-1:0]     rem0,
	input  wire logic [LANES-1:0][Q_W-1:0]     num_lo,
	input  wire logic [D_W-1:0]                den,
	input  wire logic [TAG_W-1:0]              in_tag,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [LANES-1:0][Q_W-1:0]          quo,
	output logic [TAG_W-1:0]                   out_tag
);

	logic                          v_s   [1:Q_W];
	logic [LANES-1:0][D_W-1:0]     rem_s [1:Q_W];
	logic [LANES-1:0][Q_W-1:0]     nl_s  [1:Q_W];
	logic [LANES-1:0][Q_W-1:0]     q_s   [1:Q_W];
	logic [D_W-1:0]                den_s [1:Q_W];
	logic [TAG_W-1:0]              tag_s [1:Q_W];
	logic                          rdy   [1:Q_W+1];

	assign rdy[Q_W+1] = out_ready;

	for (genvar k = 1; k <= Q_W; k++) begin : g_stage
		logic                          v_in;
		logic [LANES-1:0][D_W-1:0]     rem_in;
		logic [LANES-1:0][Q_W-1:0]     nl_in;
		logic [LANES-1:0][Q_W-1:0]     q_in;
		logic [D_W-1:0]                den_in;
		logic [TAG_W-1:0]              tag_in;
		logic [LANES-1:0][D_W-1:0]     rem_nx;
		logic [LANES-1:0][Q_W-1:0]     nl_nx;
		logic [LANES-1:0][Q_W-1:0]     q_nx;

		if (k == 1) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = rem0;
			assign nl_in  = num_lo;
			assign q_in   = '0;
			assign den_in = den;
			assign tag_in = in_tag;
		end else begin : g_next
			assign v_in   = v_s[k-1];
			assign rem_in = rem_s[k-1];
			assign nl_in  = nl_s[k-1];
			assign q_in   = q_s[k-1];
			assign den_in = den_s[k-1];
			assign tag_in = tag_s[k-1];
		end

		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_comb begin
			logic [D_W:0] r2;
			logic         ge;
			for (int l = 0; l < LANES; l++) begin
				r2        = {rem_in[l], nl_in[l][Q_W-1]};
				ge        = r2 >= {1'b0, den_in};
				rem_nx[l] = ge ? D_W'(r2 - {1'b0, den_in}) : r2[D_W-1:0];
				q_nx[l]   = {q_in[l][Q_W-2:0], ge};
				nl_nx[l]  = {nl_in[l][Q_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_in) begin
				rem_s[k] <= rem_nx;
				nl_s[k]  <= nl_nx;
				q_s[k]   <= q_nx;
				den_s[k] <= den_in;
				tag_s[k] <= tag_in;
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = v_s[Q_W];
	assign quo       = q_s[Q_W];
	assign out_tag   = tag_s[Q_W];

endmodule
`default_nettype wire

FILE: hw/rtl/radial_stick_dead_zone_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radial stick dead zone unit
// Scales an X/Y stick sample radially between a dead radius and a full radius.
// ----------------------------------------------------------------------------
// From request acceptance to result valid the path runs through two input
// stages, 24 square root stages, one compare stage, 14 scale divider stages,
// one multiply stage, 15 component divider stages and the output register.
// Throughput is one request per cycle; every stage has its own ready, so
// bubbles close up and a held result stalls a stage only once it is full.
// Reset clears all valid bits and loads the radius registers with 8000 and
// 30000; data registers are not reset.
module radial_stick_dead_zone_unit
	import rsdz_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [RAD_W-1:0]      cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic signed [15:0]    stick_x,
	input  wire logic signed [15:0]    stick_y,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [15:0]         out_x,
	output logic signed [15:0]         out_y,
	output logic                       in_dead_zone
);

	localparam int TAG1_W = 2 * MAG_W + 2;
	localparam int TAG2_W = 2 * MAG_W + 2 + LEN_W + 2;
	localparam int TAG3_W = 4;

	// Configuration registers. Writes must arrive only while the pipeline is
	// empty, so every stage can read them directly; the unit does not enforce it.
	logic [RAD_W-1:0] dead_q;
	logic [RAD_W-1:0] full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q <= DEAD_RESET;
			full_q <= FULL_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEAD_RADIUS: dead_q <= cfg_data;
				REG_FULL_RADIUS: full_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: magnitudes and signs of the two axes.
	logic             v_s1, rdy_s1;
	logic [MAG_W-1:0] mx_s1, my_s1;
	logic             nx_s1, ny_s1;

	// Stage 2: squared length.
	logic             v_s2, rdy_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [TAG1_W-1:0] tag_s2;

	logic             sq_in_ready, sq_out_valid;
	logic [LEN_W-1:0] sq_len;
	logic [TAG1_W-1:0] sq_tag;

	// Ready lines of the stages behind the two dividers and the square root.
	logic             rdy_s3, rdy_s4, rdy_s5;

	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			nx_s1 <= stick_x[15];
			ny_s1 <= stick_y[15];
			mx_s1 <= stick_x[15] ? MAG_W'(-stick_x) : MAG_W'(stick_x);
			my_s1 <= stick_y[15] ? MAG_W'(-stick_y) : MAG_W'(stick_y);
		end
	end

	assign rdy_s2 = !v_s2 || sq_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			sum_s2 <= SUM_W'(mx_s1) * SUM_W'(mx_s1) + SUM_W'(my_s1) * SUM_W'(my_s1);
			tag_s2 <= {mx_s1, my_s1, nx_s1, ny_s1};
		end
	end

	// The length carries 8 fractional bits, so the radicand is the squared
	// length shifted up by 16.
	rsdz_sqrt #(
		.RW    (LEN_W),
		.TAG_W (TAG1_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (sq_in_ready),
		.radicand  ({sum_s2, {(2 * LEN_FRAC){1'b0}}}),
		.in_tag    (tag_s2),
		.out_valid (sq_out_valid),
		.out_ready (rdy_s3),
		.root      (sq_len),
		.out_tag   (sq_tag)
	);

	// Stage 3: dead zone test and scale numerator/denominator.
	logic              v_s3;
	logic [LEN_W-1:0]  rem_s3, den_s3;
	logic [TAG2_W-1:0] tag_s3;
	logic              fd_in_ready, fd_out_valid;
	logic [0:0][OUT_FRAC_BITS-1:0] fd_quo;
	logic [TAG2_W-1:0] fd_tag;

	logic [LEN_W-1:0] d8, f8, diff3, span3;
	logic             dead3, fone3;

	always_comb begin
		d8    = {dead_q, {LEN_FRAC{1'b0}}};
		f8    = {full_q, {LEN_FRAC{1'b0}}};
		dead3 = sq_len < d8;
		diff3 = sq_len - d8;
		span3 = f8 - d8;
		// Scale saturates at 1.0 when full is not above dead or the length
		// reaches the full radius.
		fone3 = (full_q <= dead_q) || (diff3 >= span3);
	end

	assign rdy_s3 = !v_s3 || fd_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= sq_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && sq_out_valid) begin
			rem_s3 <= fone3 ? '0 : diff3;
			den_s3 <= span3;
			tag_s3 <= {sq_tag, sq_len, dead3, fone3};
		end
	end

	rsdz_div #(
		.LANES (1),
		.Q_W   (OUT_FRAC_BITS),
		.D_W   (LEN_W),
		.TAG_W (TAG2_W)
	) u_fdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (fd_in_ready),
		.rem0      (rem_s3),
		.num_lo    ('0),
		.den       (den_s3),
		.in_tag    (tag_s3),
		.out_valid (fd_out_valid),
		.out_ready (rdy_s4),
		.quo       (fd_quo),
		.out_tag   (fd_tag)
	);

	// Stage 4: scale each magnitude by f, with the length fraction applied.
	logic                          v_s4;
	logic [1:0][PROD_W-1:0]        prod_s4;
	logic [LEN_W-1:0]              len_s4;
	logic [TAG3_W-1:0]             tag_s4;
	logic                          xy_in_ready, xy_out_valid;
	logic [1:0][F_W-1:0]           xy_quo;
	logic [TAG3_W-1:0]             xy_tag;

	logic [MAG_W-1:0] mx4, my4;
	logic             nx4, ny4, dead4, fone4;
	logic [LEN_W-1:0] len4;
	logic [F_W-1:0]   f4;

	always_comb begin
		{mx4, my4, nx4, ny4, len4, dead4, fone4} = fd_tag;
		f4 = fone4 ? F_ONE : {1'b0, fd_quo[0]};
	end

	assign rdy_s4 = !v_s4 || xy_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= fd_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && fd_out_valid) begin
			prod_s4[0] <= (PROD_W'(mx4) * PROD_W'(f4)) << LEN_FRAC;
			prod_s4[1] <= (PROD_W'(my4) * PROD_W'(f4)) << LEN_FRAC;
			len_s4     <= len4;
			tag_s4     <= {nx4, ny4, dead4, len4 == '0};
		end
	end

	// The quotient never exceeds 1.0, so the upper product bits are already
	// below the length and serve as the starting remainder.
	rsdz_div #(
		.LANES (2),
		.Q_W   (F_W),
		.D_W   (LEN_W),
		.TAG_W (TAG3_W)
	) u_xydiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (xy_in_ready),
		.rem0      ({prod_s4[1][PROD_W-1:F_W], prod_s4[0][PROD_W-1:F_W]}),
		.num_lo    ({prod_s4[1][F_W-1:0], prod_s4[0][F_W-1:0]}),
		.den       (len_s4),
		.in_tag    (tag_s4),
		.out_valid (xy_out_valid),
		.out_ready (rdy_s5),
		.quo       (xy_quo),
		.out_tag   (xy_tag)
	);

	// Stage 5: output register. Dead zone and zero length give zero; the
	// sign of each input axis is restored.
	logic              v_s5;
	logic [OUT_W-1:0]  ox_s5, oy_s5;
	logic              dz_s5;
	logic              nx5, ny5, dead5, lz5;
	logic [OUT_W-1:0]  mx5, my5;

	always_comb begin
		{nx5, ny5, dead5, lz5} = xy_tag;
		mx5 = (dead5 || lz5) ? '0 : OUT_W'(xy_quo[0]);
		my5 = (dead5 || lz5) ? '0 : OUT_W'(xy_quo[1]);
	end

	assign rdy_s5 = !v_s5 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= xy_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && xy_out_valid) begin
			ox_s5 <= nx5 ? -mx5 : mx5;
			oy_s5 <= ny5 ? -my5 : my5;
			dz_s5 <= dead5;
		end
	end

	assign out_valid    = v_s5;
	assign out_x        = ox_s5;
	assign out_y        = oy_s5;
	assign in_dead_zone = dz_s5;

	// A result inside the dead zone is always zero.
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_dead_zone |-> out_x == '0 && out_y == '0)
		else $error("dead zone result is not zero");

	// The scaled vector never leaves the unit range.
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_x[15] ? (OUT_W'(-out_x) <= OUT_ONE) : (out_x <= OUT_ONE)))
		else $error("out_x beyond 1.0");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_y[15] ? (OUT_W'(-out_y) <= OUT_ONE) : (out_y <= OUT_ONE)))
		else $error("out_y beyond 1.0");

	// With the output register empty, every stage ready ripples through.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output register is empty");

endmodule
`default_nettype wire
